[rtl/core/forest_tree_counter_macros.svh]
// Assertion macros shared by the forest tree counter modules.
`ifndef FOREST_TREE_COUNTER_MACROS_SVH
`define FOREST_TREE_COUNTER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define FTC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define FTC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/ftc_pkg.sv]
// Types and constants shared by the forest tree counter modules.
package ftc_pkg;

    localparam int END_W     = 10;
    localparam int VC_W      = 11;
    localparam int TREE_W    = 11;
    localparam int VERDICT_W = 2;

    localparam logic [VERDICT_W-1:0] VERDICT_NONE   = 2'd0;
    localparam logic [VERDICT_W-1:0] VERDICT_ONE    = 2'd1;
    localparam logic [VERDICT_W-1:0] VERDICT_FOREST = 2'd2;

    typedef struct packed {
        logic             kind;
        logic [END_W-1:0] end_a;
        logic [END_W-1:0] end_b;
    } ftc_item_t;

    typedef struct packed {
        logic [TREE_W-1:0]    tree_count;
        logic [VERDICT_W-1:0] verdict;
        logic                 range_error;
    } ftc_result_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FA_CHK,
        ST_FA_HOP,
        ST_FB_CHK,
        ST_FB_HOP,
        ST_UNION
    } ftc_state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_CLEAR,
        OP_LOAD,
        OP_ERROR,
        OP_EMIT,
        OP_CHK_A,
        OP_CHK_B,
        OP_HOP,
        OP_UNION
    } ftc_op_t;

    typedef struct packed {
        ftc_op_t op;
    } ftc_cmd_t;

    typedef struct packed {
        logic in_range;
        logic is_root;
        logic same_root;
        logic clear_last;
    } ftc_status_t;

endpackage

[rtl/core/forest_tree_counter.sv]
// Top level of the forest tree counter.
//
// Input words arrive on item, accepted when start is high and busy is low.
// An edge word (kind 0) joins vertices end_a and end_b of the current case;
// an edge naming a vertex outside 1..vertex_count (at most MAX_VERTICES)
// is dropped and latches range_error. An end word (kind 1) closes the
// case: the next cycle done pulses for one cycle with result (tree_count,
// verdict, range_error). The receiver cannot stall; sample result whenever
// done is high. vertex_count is written through cfg_we / cfg_wdata; the user
// must write it only while the block is idle; the block does not enforce it.
// An edge word is loaded, then each endpoint is followed up its parent links
// to its root, each hop rereading the parent from the registered-read store,
// and a union step follows when the two roots differ and components merge.
// An out-of-range edge is dropped in the idle state without leaving it.
// After an end word, and after reset, the store is swept one entry a cycle,
// entries 0 to MAX_VERTICES, with busy high until the sweep ends.
// Reset returns vertex_count to 1 and clears counters and the error flag.
module forest_tree_counter
    import ftc_pkg::*;
#(
    parameter int MAX_VERTICES = 1024
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  ftc_item_t       item,
    output logic            done,
    output ftc_result_t     result,
    input  logic            cfg_we,
    input  logic [VC_W-1:0] cfg_wdata
);

    ftc_cmd_t    cmd;
    ftc_status_t status;

    ftc_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .kind   (item.kind),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    ftc_datapath #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .item      (item),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .status    (status),
        .done      (done),
        .result    (result)
    );

endmodule

[rtl/core/ftc_ctrl.sv]
// Sequencing state machine for the forest tree counter.
`include "forest_tree_counter_macros.svh"

module ftc_ctrl
    import ftc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        kind,
    input  ftc_status_t status,
    output ftc_cmd_t    cmd,
    output logic        busy
);

    ftc_state_t state_reg;
    ftc_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        busy       = 1'b1;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.op = OP_CLEAR;
                if (status.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    if (kind)
                    begin
                        cmd.op     = OP_EMIT;
                        state_next = ST_CLEAR;
                    end
                    else if (status.in_range)
                    begin
                        cmd.op     = OP_LOAD;
                        state_next = ST_FA_CHK;
                    end
                    else
                    begin
                        cmd.op = OP_ERROR;
                    end
                end
            end
            ST_FA_CHK:
            begin
                cmd.op     = OP_CHK_A;
                state_next = status.is_root ? ST_FB_CHK : ST_FA_HOP;
            end
            ST_FA_HOP:
            begin
                cmd.op     = OP_HOP;
                state_next = ST_FA_CHK;
            end
            ST_FB_CHK:
            begin
                cmd.op = OP_CHK_B;
                if (!status.is_root)
                begin
                    state_next = ST_FB_HOP;
                end
                else if (status.same_root)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_UNION;
                end
            end
            ST_FB_HOP:
            begin
                cmd.op     = OP_HOP;
                state_next = ST_FB_CHK;
            end
            ST_UNION:
            begin
                cmd.op     = OP_UNION;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    `FTC_ASSERT_NEXT(a_end_clears, state_reg == ST_IDLE && start && kind, state_reg == ST_CLEAR, "end word did not start the clearing pass")
    `FTC_ASSERT_NEXT(a_hop_returns, state_reg == ST_FA_HOP, state_reg == ST_FA_CHK, "hop did not return to root check")
    `FTC_ASSERT_NEXT(a_union_done, state_reg == ST_UNION, state_reg == ST_IDLE, "union did not finish the edge")

endmodule

[rtl/core/ftc_datapath.sv]
// Union-find store, counters and result register of the forest tree counter.
`include "forest_tree_counter_macros.svh"

module ftc_datapath
    import ftc_pkg::*;
#(
    parameter int MAX_VERTICES = 1024
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  ftc_cmd_t         cmd,
    input  ftc_item_t        item,
    input  logic             cfg_we,
    input  logic [VC_W-1:0]  cfg_wdata,
    output ftc_status_t      status,
    output logic             done,
    output ftc_result_t      result
);

    localparam int AW = $clog2(MAX_VERTICES + 1);
    localparam int WW = (AW > VC_W) ? AW : VC_W;
    localparam logic [WW-1:0] MAX_W = WW'(MAX_VERTICES);
    localparam logic [AW-1:0] MAX_A = AW'(MAX_VERTICES);

    logic [AW:0] mem [0:MAX_VERTICES];
    logic [AW:0] rd_data_reg;

    logic [VC_W-1:0] vcount_reg, vcount_next;
    logic [AW-1:0]   merge_reg, merge_next;
    logic [AW-1:0]   cyc_reg, cyc_next;
    logic            err_reg, err_next;
    logic [AW-1:0]   clr_reg, clr_next;
    logic            done_reg, done_next;

    logic [AW-1:0] v_reg, v_next;
    logic [AW-1:0] b_reg, b_next;
    logic [AW-1:0] ra_reg, ra_next;
    logic          ma_reg, ma_next;
    logic          mb_reg, mb_next;
    ftc_result_t   result_reg, result_next;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [AW:0]   wr_data;
    logic [AW-1:0] rd_addr;

    logic [WW-1:0] n_w, a_w, b_w;
    logic [AW-1:0] n_a;
    logic [AW-1:0] link;
    logic          mark;
    logic [AW:0]   used;
    logic [AW:0]   trees;

    assign n_w  = (WW'(vcount_reg) > MAX_W) ? MAX_W : WW'(vcount_reg);
    assign n_a  = AW'(n_w);
    assign a_w  = WW'(item.end_a);
    assign b_w  = WW'(item.end_b);
    assign link = rd_data_reg[AW-1:0];
    assign mark = rd_data_reg[AW];
    assign used = {1'b0, merge_reg} + {1'b0, cyc_reg};
    assign trees = ({1'b0, n_a} > used) ? ({1'b0, n_a} - used) : '0;

    assign status.in_range   = (a_w != '0) && (b_w != '0) && (a_w <= n_w) && (b_w <= n_w);
    assign status.is_root    = (link == v_reg);
    assign status.same_root  = (v_reg == ra_reg);
    assign status.clear_last = (clr_reg == MAX_A);

    always_comb
    begin
        vcount_next = cfg_we ? cfg_wdata : vcount_reg;
        merge_next  = merge_reg;
        cyc_next    = cyc_reg;
        err_next    = err_reg;
        clr_next    = clr_reg;
        done_next   = 1'b0;
        v_next      = v_reg;
        b_next      = b_reg;
        ra_next     = ra_reg;
        ma_next     = ma_reg;
        mb_next     = mb_reg;
        result_next = result_reg;
        wr_en       = 1'b0;
        wr_addr     = v_reg;
        wr_data     = {1'b0, v_reg};
        rd_addr     = v_reg;
        unique case (cmd.op)
            OP_NONE:
            begin
            end
            OP_CLEAR:
            begin
                wr_en    = 1'b1;
                wr_addr  = clr_reg;
                wr_data  = {1'b0, clr_reg};
                clr_next = clr_reg + 1'b1;
            end
            OP_LOAD:
            begin
                v_next  = AW'(item.end_a);
                b_next  = AW'(item.end_b);
                rd_addr = AW'(item.end_a);
            end
            OP_ERROR:
            begin
                err_next = 1'b1;
            end
            OP_EMIT:
            begin
                done_next               = 1'b1;
                result_next.tree_count  = TREE_W'(trees);
                result_next.range_error = err_reg;
                if (trees == '0)
                begin
                    result_next.verdict = VERDICT_NONE;
                end
                else if (trees == (AW+1)'(1))
                begin
                    result_next.verdict = VERDICT_ONE;
                end
                else
                begin
                    result_next.verdict = VERDICT_FOREST;
                end
                merge_next = '0;
                cyc_next   = '0;
                err_next   = 1'b0;
                clr_next   = '0;
            end
            OP_CHK_A:
            begin
                if (link == v_reg)
                begin
                    ra_next = v_reg;
                    ma_next = mark;
                    v_next  = b_reg;
                    rd_addr = b_reg;
                end
                else
                begin
                    rd_addr = link;
                end
            end
            OP_HOP:
            begin
                wr_en   = 1'b1;
                wr_addr = v_reg;
                wr_data = {1'b0, link};
                v_next  = link;
                rd_addr = link;
            end
            OP_CHK_B:
            begin
                if (link != v_reg)
                begin
                    rd_addr = link;
                end
                else if (v_reg == ra_reg)
                begin
                    if (!ma_reg)
                    begin
                        wr_en    = 1'b1;
                        wr_addr  = ra_reg;
                        wr_data  = {1'b1, ra_reg};
                        cyc_next = cyc_reg + 1'b1;
                    end
                end
                else
                begin
                    wr_en      = 1'b1;
                    wr_addr    = v_reg;
                    wr_data    = {1'b0, ra_reg};
                    mb_next    = mark;
                    merge_next = merge_reg + 1'b1;
                    if (ma_reg && mark)
                    begin
                        cyc_next = cyc_reg - 1'b1;
                    end
                end
            end
            OP_UNION:
            begin
                wr_en   = 1'b1;
                wr_addr = ra_reg;
                wr_data = {ma_reg | mb_reg, ra_reg};
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcount_reg <= VC_W'(1);
            merge_reg  <= '0;
            cyc_reg    <= '0;
            err_reg    <= 1'b0;
            clr_reg    <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            vcount_reg <= vcount_next;
            merge_reg  <= merge_next;
            cyc_reg    <= cyc_next;
            err_reg    <= err_next;
            clr_reg    <= clr_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg      <= v_next;
        b_reg      <= b_next;
        ra_reg     <= ra_next;
        ma_reg     <= ma_next;
        mb_reg     <= mb_next;
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    `FTC_ASSERT_NOW(a_done_sweep_start, done_reg, clr_reg == '0, "clearing pass not restarted with result")
    `FTC_ASSERT_NOW(a_done_counts_zero, done_reg, merge_reg == '0 && cyc_reg == '0 && !err_reg, "case counters not cleared with result")

endmodule

[verif/tb.sv]
// Self-checking testbench for the forest tree counter: directed graphs, then random cases.
`timescale 1ns / 1ps

module tb;
    import ftc_pkg::*;

    localparam int MAXV = 1024;
    localparam int ITEM_TARGET = 1300;
    localparam int EDGE_SETTLE = 16;
    localparam int LIMIT_CYCLES = 4000000;
    localparam logic KIND_EDGE = 1'b0;
    localparam logic KIND_END = 1'b1;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    ftc_item_t item;
    logic done;
    ftc_result_t result;
    logic cfg_we;
    logic [VC_W-1:0] cfg_wdata;

    forest_tree_counter uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    int unsigned link_of [0:MAXV];
    bit loop_of [0:MAXV];
    int unsigned join_total;
    int unsigned loop_roots;
    bit range_seen;
    logic [VC_W-1:0] vcount;

    ftc_result_t pending_counts[$];
    int failures;
    int checked_words;
    int edge_words;
    int counted_words;
    int idle_pct;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        repeat (LIMIT_CYCLES) @(posedge clk);
        $display("forest_tree_counter regression: fail");
        $finish;
    end

    function automatic void forget_graph();
        for (int i = 0; i <= MAXV; i++)
        begin
            link_of[i] = i;
            loop_of[i] = 1'b0;
        end
        join_total = 0;
        loop_roots = 0;
        range_seen = 1'b0;
    endfunction

    function automatic int unsigned root_of(int unsigned v);
        while (link_of[v] != v)
        begin
            link_of[v] = link_of[link_of[v]];
            v = link_of[v];
        end
        return v;
    endfunction

    function automatic int unsigned live_vertices();
        return (vcount < MAXV) ? vcount : MAXV;
    endfunction

    function automatic void count_word(ftc_item_t w);
        int unsigned n;
        int unsigned a;
        int unsigned b;
        int unsigned ra;
        int unsigned rb;
        int unsigned used;
        int unsigned trees;
        ftc_result_t r;
        n = live_vertices();
        if (w.kind == KIND_EDGE)
        begin
            a = w.end_a;
            b = w.end_b;
            if (a < 1 || b < 1 || a > n || b > n)
            begin
                range_seen = 1'b1;
                return;
            end
            ra = root_of(a);
            rb = root_of(b);
            if (ra == rb)
            begin
                if (!loop_of[ra])
                begin
                    loop_of[ra] = 1'b1;
                    loop_roots++;
                end
                return;
            end
            if (loop_of[ra] && loop_of[rb])
                loop_roots--;
            link_of[rb] = ra;
            loop_of[ra] = loop_of[ra] | loop_of[rb];
            loop_of[rb] = 1'b0;
            join_total++;
        end
        else
        begin
            used = join_total + loop_roots;
            trees = (n > used) ? n - used : 0;
            r.tree_count = trees[TREE_W-1:0];
            if (trees == 0)
                r.verdict = VERDICT_NONE;
            else if (trees == 1)
                r.verdict = VERDICT_ONE;
            else
                r.verdict = VERDICT_FOREST;
            r.range_error = range_seen;
            pending_counts = {pending_counts, r};
            forget_graph();
        end
    endfunction

    function automatic ftc_item_t make_word(logic kind, int unsigned a, int unsigned b);
        ftc_item_t w;
        w.kind = kind;
        w.end_a = a[END_W-1:0];
        w.end_b = b[END_W-1:0];
        return w;
    endfunction

    always @(posedge clk)
    begin
        ftc_result_t want;
        if (rst_n && done)
        begin
            if (pending_counts.size() == 0)
            begin
                $error("result word with none expected: tree_count %0d", result.tree_count);
                failures++;
            end
            else
            begin
                want = pending_counts.pop_front();
                checked_words++;
                if (result.tree_count !== want.tree_count)
                begin
                    $error("tree_count: expected %0d, got %0d", want.tree_count,
                           result.tree_count);
                    failures++;
                end
                if (result.verdict !== want.verdict)
                begin
                    $error("verdict: expected %0d, got %0d", want.verdict, result.verdict);
                    failures++;
                end
                if (result.range_error !== want.range_error)
                begin
                    $error("range_error: expected %0d, got %0d", want.range_error,
                           result.range_error);
                    failures++;
                end
            end
        end
    end

    task automatic send_word(ftc_item_t w);
        start <= 1'b1;
        item <= w;
        do
            @(posedge clk);
        while (busy);
        count_word(w);
        if (w.kind == KIND_EDGE)
            edge_words++;
        if ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    task automatic send_edge(int unsigned a, int unsigned b);
        send_word(make_word(KIND_EDGE, a, b));
    endtask

    task automatic send_end();
        send_word(make_word(KIND_END, $urandom_range(0, 1023), $urandom_range(0, 1023)));
    endtask

    task automatic drain();
        start <= 1'b0;
        while (pending_counts.size() != 0)
            @(posedge clk);
        repeat (EDGE_SETTLE) @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic set_vertex_count(int unsigned v);
        drain();
        cfg_we <= 1'b1;
        cfg_wdata <= v[VC_W-1:0];
        @(posedge clk);
        vcount = v[VC_W-1:0];
        cfg_we <= 1'b0;
    endtask

    task automatic test_reset_state();
        send_end();
        send_edge(1, 1);
        send_end();
    endtask

    task automatic test_small_graphs();
        set_vertex_count(6);
        send_edge(1, 2);
        send_edge(2, 3);
        send_edge(3, 1);
        send_edge(4, 5);
        send_edge(5, 4);
        send_end();
        send_edge(1, 2);
        send_edge(3, 4);
        send_end();
    endtask

    task automatic test_range_errors();
        set_vertex_count(4);
        send_edge(0, 1);
        send_edge(1, 5);
        send_edge(1023, 0);
        send_edge(2, 3);
        send_end();
        set_vertex_count(0);
        send_edge(1, 1);
        send_end();
    endtask

    task automatic test_vertex_count_extremes();
        set_vertex_count(2047);
        send_end();
        set_vertex_count(1024);
        send_edge(1023, 1);
        send_edge(512, 1023);
        send_end();
    endtask

    task automatic test_mid_case_resize();
        set_vertex_count(8);
        send_edge(1, 2);
        send_edge(3, 3);
        set_vertex_count(2);
        send_end();
    endtask

    function automatic int unsigned pick_vertex_count();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 2)
            return $urandom_range(0, 1) ? 1024 : 2047;
        if (r < 4)
            return $urandom_range(0, 2047);
        if (r < 8)
            return $urandom_range(0, 1);
        return $urandom_range(2, 40);
    endfunction

    task automatic run_random_case();
        int unsigned hi;
        int unsigned edges;
        int unsigned resize_at;
        if (vcount == 1 || $urandom_range(1))
            set_vertex_count(pick_vertex_count());
        hi = (live_vertices() > 1023) ? 1023 : live_vertices();
        edges = $urandom_range(0, (2 * hi + 2 < 60) ? 2 * hi + 2 : 60);
        resize_at = ($urandom_range(99) < 8) ? $urandom_range(0, edges) : edges + 1;
        for (int unsigned i = 0; i < edges; i++)
        begin
            if (i == resize_at)
            begin
                set_vertex_count($urandom_range(0, 40));
                hi = live_vertices();
            end
            if (hi == 0 || $urandom_range(99) < 8)
                send_edge($urandom_range(0, 1023), $urandom_range(0, 1023));
            else
            begin
                send_edge($urandom_range(1, hi), $urandom_range(1, hi));
                counted_words++;
            end
        end
        send_end();
        counted_words++;
    endtask

    task automatic test_random_cases();
        int sender_idle [4] = '{0, 55, 0, 20};
        for (int phase = 0; phase < 4; phase++)
        begin
            idle_pct = sender_idle[phase];
            while (counted_words < ITEM_TARGET * (phase + 1) / 4)
                run_random_case();
        end
        idle_pct = 0;
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        item = '0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        failures = 0;
        checked_words = 0;
        edge_words = 0;
        counted_words = 0;
        idle_pct = 0;
        vcount = 1;
        forget_graph();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_state();
        test_small_graphs();
        test_range_errors();
        test_vertex_count_extremes();
        test_mid_case_resize();
        test_random_cases();

        start <= 1'b0;
        while (pending_counts.size() != 0)
            @(posedge clk);
        repeat (EDGE_SETTLE) @(posedge clk);

        $display("checked %0d case results built from %0d edge words", checked_words,
                 edge_words);
        $display("vertex counts 0 to 2047, range errors, resizes mid-case, sender gaps");
        if (failures == 0)
            $display("forest_tree_counter regression: pass");
        else
            $display("forest_tree_counter regression: fail");
        $finish;
    end

endmodule
